>>> design/u2ra_pkg.sv
// Shared types, constants and helper functions of the radix-to-ASCII converter.
package u2ra_pkg;

    localparam int DEF_VALUE_BITS = 64;
    localparam int BITS_PER_CYCLE = 8;   // dividend bits retired per divide cycle

    localparam int RADIX_W    = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;
    localparam int CHAR_W     = 8;
    localparam int DIGIT_W    = 4;

    localparam logic [CFG_IDX_W-1:0] REG_RADIX = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_UPPER = 1'b1;

    localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd16;

    localparam logic [CHAR_W-1:0] ASCII_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] ASCII_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] ASCII_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] TEN           = 8'd10;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_EMIT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic step;
        logic emit;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic div_done;   // current divide cycle finishes a digit
        logic quot_zero;  // quotient after this cycle is zero
        logic rd_last;    // read pointer at least significant digit
    } stat_t;

    // Out-of-range radix codes saturate into 2..16.
    function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
        logic [RADIX_W-1:0] res;
        res = r;
        if (r < RADIX_MIN)
            res = RADIX_MIN;
        else if (r > RADIX_MAX)
            res = RADIX_MAX;
        return res;
    endfunction

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
                                                     input logic up);
        logic [CHAR_W-1:0] d8;
        logic [CHAR_W-1:0] res;
        d8 = {4'h0, d};
        if (d8 < TEN)
            res = ASCII_ZERO + d8;
        else
            res = (up ? ASCII_UPPER_A : ASCII_LOWER_A) + d8 - TEN;
        return res;
    endfunction

endpackage

>>> design/u2ra_ctrl.sv
// Sequencing state machine: load, repeated division, digit read-out.
module u2ra_ctrl
    import u2ra_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  stat_t stat,
    output cmd_t  cmd,
    output logic  busy
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                cmd.step = 1'b1;
                if (stat.div_done && stat.quot_zero)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                cmd.emit = 1'b1;
                if (stat.rd_last)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> design/u2ra_dp.sv
// Datapath: shift-subtract divider, digit store and character output register.
module u2ra_dp
    import u2ra_pkg::*;
#(
    parameter int VALUE_BITS = DEF_VALUE_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cmd_t                  cmd,
    input  logic [VALUE_BITS-1:0] value,
    input  logic [RADIX_W-1:0]    radix,
    input  logic                  upper_case,
    output stat_t                 stat,
    output logic [CHAR_W-1:0]     character,
    output logic                  last,
    output logic                  strobe
);

    // dividend padded to whole divide cycles
    localparam int STEPS = (VALUE_BITS + BITS_PER_CYCLE - 1) / BITS_PER_CYCLE;
    localparam int W     = STEPS * BITS_PER_CYCLE;
    localparam int SW    = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam int AW    = $clog2(VALUE_BITS);

    logic [W-1:0]       work_reg;
    logic [DIGIT_W-1:0] rem_reg;
    logic [SW-1:0]      step_reg;
    logic [AW-1:0]      cnt_reg;
    logic [AW-1:0]      ptr_reg;
    logic [DIGIT_W-1:0] rd_digit_reg;
    logic               strobe_reg;
    logic               last_reg;

    logic [DIGIT_W-1:0] digit_mem [VALUE_BITS];

    logic [BITS_PER_CYCLE-1:0] qbits;
    logic [DIGIT_W-1:0]        rem_next;
    logic [W-1:0]              work_next;

    // Eight restoring division steps; the partial remainder stays below the radix.
    always_comb
    begin
        logic [RADIX_W-1:0] r;
        r = {1'b0, rem_reg};
        qbits = '0;
        for (int i = 0; i < BITS_PER_CYCLE; i++)
        begin
            r = {r[DIGIT_W-1:0], work_reg[W-1-i]};
            if (r >= radix)
            begin
                r = r - radix;
                qbits[BITS_PER_CYCLE-1-i] = 1'b1;
            end
        end
        rem_next  = r[DIGIT_W-1:0];
        work_next = W'({work_reg, qbits});
    end

    assign stat.div_done  = (step_reg == SW'(STEPS - 1));
    assign stat.quot_zero = (work_next == '0);
    assign stat.rd_last   = (ptr_reg == '0);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            work_reg <= W'(value);
            rem_reg  <= '0;
            step_reg <= '0;
            cnt_reg  <= '0;
        end
        else if (cmd.step)
        begin
            work_reg <= work_next;
            if (stat.div_done)
            begin
                digit_mem[cnt_reg] <= rem_next;
                cnt_reg  <= cnt_reg + 1'b1;
                rem_reg  <= '0;
                step_reg <= '0;
                if (stat.quot_zero)
                    ptr_reg <= cnt_reg;
            end
            else
            begin
                rem_reg  <= rem_next;
                step_reg <= step_reg + 1'b1;
            end
        end
        else if (cmd.emit)
        begin
            ptr_reg <= ptr_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
            rd_digit_reg <= digit_mem[ptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
            last_reg   <= 1'b0;
        end
        else
        begin
            strobe_reg <= cmd.emit;
            last_reg   <= cmd.emit && stat.rd_last;
        end
    end

    assign character = digit_char(rd_digit_reg, upper_case);
    assign last      = last_reg;
    assign strobe    = strobe_reg;

`ifndef NO_ASSERTIONS
    a_rem_below_radix: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> ({1'b0, rem_reg} < radix))
        else $error("partial remainder not below radix");

    a_digit_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step && stat.div_done && cnt_reg == AW'(VALUE_BITS - 1)) |-> stat.quot_zero)
        else $error("digit count exceeds value width");

    a_last_on_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        last_reg |-> (strobe_reg && $past(cmd.emit)))
        else $error("last flag without character strobe");
`endif

endmodule

>>> design/unsigned_to_radix_ascii_unit.sv
// Top level of the unsigned integer to ASCII digit converter.
//
// Converts one unsigned VALUE_BITS-wide value into ASCII digits in a radix of
// 2..16, most significant digit first, without leading zeros; zero gives "0".
// A value is taken on a clock edge with start high and busy low. Characters
// then come out one per cycle on character, each marked by a one-cycle strobe,
// with last high on the final one; the receiver must take each character in
// the cycle it is shown. Digits are found by repeated division of the value by
// the radix, least significant first, in a shift-subtract divider that retires
// eight dividend bits per cycle and passes over the whole value for each digit;
// the digits are kept in a small digit store and read back in reverse, one per
// cycle. Busy stays high from the transfer until the last digit is read out,
// and the last character is shown in the first cycle that busy is low again.
// Configuration: index 0 sets the radix (codes below 2 act as 2, above 16 as
// 16, reset 16); index 1 bit 0 picks upper case letters (reset lower case).
// The configuration port is always ready; write it only while no conversion
// is in flight.
module unsigned_to_radix_ascii_unit
    import u2ra_pkg::*;
#(
    parameter int VALUE_BITS = DEF_VALUE_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // item transfer
    input  logic                  start,
    output logic                  busy,
    input  logic [VALUE_BITS-1:0] value,
    // configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // character stream
    output logic                  strobe,
    output logic [CHAR_W-1:0]     character,
    output logic                  last
);

    cmd_t  cmd;
    stat_t stat;

    // radix is held already clamped into 2..16
    logic [RADIX_W-1:0] radix_reg;
    logic               upper_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= RADIX_RESET;
            upper_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_RADIX: radix_reg <= clamp_radix(cfg_data);
                REG_UPPER: upper_reg <= cfg_data[0];
                default:   ;
            endcase
        end
    end

    u2ra_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    u2ra_dp #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .value      (value),
        .radix      (radix_reg),
        .upper_case (upper_reg),
        .stat       (stat),
        .character  (character),
        .last       (last),
        .strobe     (strobe)
    );

endmodule
